[design/contact_impulse_cache_unit_defines.svh]
// Assertion macros for the contact impulse cache unit.
`ifndef CONTACT_IMPULSE_CACHE_UNIT_DEFINES_SVH
`define CONTACT_IMPULSE_CACHE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CIC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CIC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/cic_pkg.sv]
// Types and constants of the contact impulse cache.
`timescale 1ns / 1ps

package cic_pkg;

	localparam int unsigned ENTRIES_DEF = 64;
	localparam int unsigned POINTS_DEF  = 4;

	localparam int unsigned KEY_W  = 64;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CNT_W  = 4;
	localparam int unsigned RCNT_W = 7;

	localparam logic [2:0] KIND_LOOKUP = 3'd0;
	localparam logic [2:0] KIND_STORE  = 3'd1;
	localparam logic [2:0] KIND_BEGIN  = 3'd2;
	localparam logic [2:0] KIND_SWEEP  = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_POINTS,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  cnt;
		logic [WORD_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [WORD_W-1:0] feature;
		logic [WORD_W-1:0] normal;
		logic [WORD_W-1:0] tan_a;
		logic [WORD_W-1:0] tan_b;
	} point_t;

endpackage

[design/cic_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module cic_ram import cic_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[design/contact_impulse_cache_unit.sv]
// Contact impulse cache: one entry RAM scanned a slot per cycle through one shared comparator.
// Lookup scans the entries and then, on a hit, the points of the hit slot; store scans the
// entries and then writes the found slot; end frame sweep and clear scan the entries only.
// One word is in work at a time; the next is taken once the result sits in the output register.
// After reset the block runs a clearing pass over the entry RAM before it takes the first word;
// the frame counter resets to zero.
`timescale 1ns / 1ps
`include "contact_impulse_cache_unit_defines.svh"

module contact_impulse_cache_unit import cic_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned POINTS  = POINTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pair_key, feature_id, point_index, point_count, normal_in, tangent_a_in, tangent_b_in
	input  logic [199:0] s_tdata,
	// kind
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit, normal_out, tangent_a_out, tangent_b_out, full_flag, removed_count
	output logic [111:0] m_tdata
);

	localparam int unsigned AW     = $clog2(ENTRIES);
	localparam int unsigned IW     = $clog2(ENTRIES + 1);
	localparam int unsigned PDEPTH = ENTRIES * POINTS;
	localparam int unsigned PAW    = $clog2(PDEPTH);
	localparam int unsigned PW     = $clog2(POINTS + 1);
	localparam int unsigned EW     = $bits(entry_t);
	localparam int unsigned PTW    = $bits(point_t);

	state_t state_q, state_d;

	logic [IW-1:0]     idx_q;
	logic              pend_q;
	logic [AW-1:0]     pend_idx_q;
	logic              free_vld_q;
	logic [AW-1:0]     free_idx_q;
	logic [AW-1:0]     slot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PW-1:0]     pt_q;
	logic              pt_pend_q;
	logic [PW-1:0]     pt_pend_idx_q;
	logic [WORD_W-1:0] frame_q;

	logic [2:0]        kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [WORD_W-1:0] fid_q;
	logic [1:0]        pidx_q;
	logic [CNT_W-1:0]  pcnt_q;
	logic [WORD_W-1:0] normal_q;
	logic [WORD_W-1:0] tan_a_q;
	logic [WORD_W-1:0] tan_b_q;

	logic              res_hit_q;
	logic [WORD_W-1:0] res_normal_q;
	logic [WORD_W-1:0] res_tan_a_q;
	logic [WORD_W-1:0] res_tan_b_q;
	logic              res_full_q;
	logic [RCNT_W-1:0] removed_q;

	logic              m_tvalid_q;
	logic [111:0]      m_tdata_q;

	logic              ent_we;
	logic [AW-1:0]     ent_waddr;
	entry_t            ent_wdata;
	logic [AW-1:0]     ent_raddr;
	logic [EW-1:0]     ent_rdata;
	entry_t            ent_rd;
	logic              pt_we;
	logic [PAW-1:0]    pt_waddr;
	point_t            pt_wdata;
	logic [PAW-1:0]    pt_raddr;
	logic [PTW-1:0]    pt_rdata;
	point_t            pt_rd;

	logic [KEY_W-1:0]  cmp_a;
	logic [KEY_W-1:0]  cmp_b;
	logic              cmp_eq;

	logic              accept;
	logic              scan_issue;
	logic              ent_last;
	logic              ent_hitk;
	logic              sweep_kill;
	logic              pt_issue;
	logic              pt_last;
	logic              pt_match;
	logic              out_load;
	logic [PAW-1:0]    pt_base;
	logic [PW-1:0]     pt_off;
	logic [2:0]        pcnt_in;

	assign ent_rd = entry_t'(ent_rdata);
	assign pt_rd  = point_t'(pt_rdata);

	cic_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	cic_ram #(.WIDTH(PTW), .DEPTH(PDEPTH)) u_point_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	// One equality comparator serves key search, stamp check and feature search.
	always_comb begin
		cmp_a = '0;
		cmp_b = '0;
		case (state_q)
			ST_SCAN: begin
				if (kind_q == KIND_SWEEP) begin
					cmp_a = {{(KEY_W-WORD_W){1'b0}}, ent_rd.stamp};
					cmp_b = {{(KEY_W-WORD_W){1'b0}}, frame_q};
				end else begin
					cmp_a = ent_rd.key;
					cmp_b = key_q;
				end
			end
			ST_POINTS: begin
				cmp_a = {{(KEY_W-WORD_W){1'b0}}, pt_rd.feature};
				cmp_b = {{(KEY_W-WORD_W){1'b0}}, fid_q};
			end
			default: ;
		endcase
	end

	assign cmp_eq = (cmp_a == cmp_b);

	assign accept     = s_tvalid && s_tready;
	assign scan_issue = (idx_q < IW'(ENTRIES));
	assign ent_last   = pend_q && (pend_idx_q == AW'(ENTRIES - 1));
	assign ent_hitk   = pend_q && ent_rd.valid && cmp_eq;
	assign sweep_kill = pend_q && ent_rd.valid && !cmp_eq;
	assign pt_issue   = (CNT_W'(pt_q) < cnt_q);
	assign pt_last    = pt_pend_q && (CNT_W'(pt_pend_idx_q) == cnt_q - CNT_W'(1));
	assign pt_match   = pt_pend_q && cmp_eq;
	assign out_load   = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign pt_base    = PAW'(slot_q) * PAW'(POINTS);
	assign pt_off     = pt_issue ? pt_q : '0;
	assign pcnt_in    = s_tdata[100:98];

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ent_we    = 1'b0;
		ent_waddr = pend_idx_q;
		ent_wdata = ent_rd;
		ent_wdata.valid = 1'b0;
		ent_raddr = idx_q[AW-1:0];
		pt_we     = 1'b0;
		pt_waddr  = pt_base + PAW'(pidx_q);
		pt_wdata  = '{feature: fid_q, normal: normal_q, tan_a: tan_a_q, tan_b: tan_b_q};
		pt_raddr  = pt_base + PAW'(pt_off);
		case (state_q)
			ST_INIT: begin
				ent_we    = 1'b1;
				ent_waddr = idx_q[AW-1:0];
				ent_wdata = '0;
				if (idx_q == IW'(ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (s_tuser)
						KIND_LOOKUP, KIND_STORE, KIND_SWEEP, KIND_CLEAR: state_d = ST_SCAN;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				case (kind_q)
					KIND_LOOKUP: begin
						if (ent_hitk) begin
							state_d = (ent_rd.cnt == '0) ? ST_DONE : ST_POINTS;
						end else if (ent_last) begin
							state_d = ST_DONE;
						end
					end
					KIND_STORE: begin
						if (ent_hitk) begin
							state_d = ST_WRITE;
						end else if (ent_last) begin
							state_d = (free_vld_q || !ent_rd.valid) ? ST_WRITE : ST_DONE;
						end
					end
					default: begin
						// Sweep drops stale entries; clear drops every entry.
						ent_we = pend_q && ((kind_q == KIND_CLEAR) || sweep_kill);
						if (ent_last) begin
							state_d = ST_DONE;
						end
					end
				endcase
			end
			ST_POINTS: begin
				if (pt_match || pt_last) begin
					state_d = ST_DONE;
				end
			end
			ST_WRITE: begin
				ent_we    = 1'b1;
				ent_waddr = slot_q;
				ent_wdata = '{valid: 1'b1, key: key_q, cnt: pcnt_q, stamp: frame_q};
				pt_we     = (32'(pidx_q) < POINTS);
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			idx_q         <= '0;
			pend_q        <= 1'b0;
			pt_pend_q     <= 1'b0;
			frame_q       <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_INIT: begin
					idx_q <= (state_d == ST_IDLE) ? '0 : idx_q + IW'(1);
				end
				ST_IDLE: begin
					idx_q  <= '0;
					pend_q <= 1'b0;
					if (accept && (s_tuser == KIND_BEGIN)) begin
						frame_q <= frame_q + WORD_W'(1);
					end
				end
				ST_SCAN: begin
					pend_q    <= scan_issue && (state_d == ST_SCAN);
					idx_q     <= idx_q + IW'(scan_issue);
					pt_pend_q <= 1'b0;
				end
				ST_POINTS: begin
					pt_pend_q <= pt_issue;
				end
				default: ;
			endcase
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload and scan bookkeeping.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q       <= s_tuser;
				key_q        <= s_tdata[63:0];
				fid_q        <= s_tdata[95:64];
				pidx_q       <= s_tdata[97:96];
				pcnt_q       <= (32'(pcnt_in) > POINTS) ? CNT_W'(POINTS) : CNT_W'(pcnt_in);
				normal_q     <= s_tdata[132:101];
				tan_a_q      <= s_tdata[164:133];
				tan_b_q      <= s_tdata[196:165];
				free_vld_q   <= 1'b0;
				res_hit_q    <= 1'b0;
				res_normal_q <= '0;
				res_tan_a_q  <= '0;
				res_tan_b_q  <= '0;
				res_full_q   <= 1'b0;
				removed_q    <= '0;
			end
			ST_SCAN: begin
				pend_idx_q <= idx_q[AW-1:0];
				pt_q       <= '0;
				if (pend_q && !ent_rd.valid && !free_vld_q) begin
					free_vld_q <= 1'b1;
					free_idx_q <= pend_idx_q;
				end
				case (kind_q)
					KIND_LOOKUP: begin
						if (ent_hitk) begin
							slot_q <= pend_idx_q;
							cnt_q  <= ent_rd.cnt;
						end
					end
					KIND_STORE: begin
						if (ent_hitk) begin
							slot_q <= pend_idx_q;
						end else if (ent_last) begin
							slot_q     <= free_vld_q ? free_idx_q : pend_idx_q;
							res_full_q <= !free_vld_q && ent_rd.valid;
						end
					end
					KIND_SWEEP: begin
						if (sweep_kill && (removed_q != '1)) begin
							removed_q <= removed_q + RCNT_W'(1);
						end
					end
					default: ;
				endcase
			end
			ST_POINTS: begin
				pt_pend_idx_q <= pt_q;
				pt_q          <= pt_q + PW'(pt_issue);
				if (pt_match) begin
					res_hit_q    <= 1'b1;
					res_normal_q <= pt_rd.normal;
					res_tan_a_q  <= pt_rd.tan_a;
					res_tan_b_q  <= pt_rd.tan_b;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			m_tdata_q <= {7'b0, removed_q, res_full_q, res_tan_b_q, res_tan_a_q,
				res_normal_q, res_hit_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`CIC_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "input taken while busy")
	`CIC_ASSERT_NOW(a_scan_no_clash, (state_q == ST_SCAN) && ent_we && scan_issue,
		ent_waddr != ent_raddr, "entry write and read collide during scan")
	`CIC_ASSERT_NOW(a_hit_exclusive, m_tvalid_q && m_tdata_q[0],
		(m_tdata_q[97] == 1'b0) && (m_tdata_q[104:98] == '0),
		"hit reported with full or removed count")
	`CIC_ASSERT_NOW(a_removed_bound, m_tvalid_q, 32'(m_tdata_q[104:98]) <= ENTRIES,
		"removed count exceeds table size")

endmodule
